@@ rtl/tzda_pkg.sv @@
`default_nettype none

package tzda_pkg;

  // Calendar constants
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthJul = 4'd7;
  localparam logic [3:0] MonthAug = 4'd8;
  localparam logic [3:0] MonthDec = 4'd12;
  localparam logic [4:0] DaysLong = 5'd31;
  localparam logic [4:0] DaysShort = 5'd30;
  localparam logic [4:0] DaysFebLeap = 5'd29;
  localparam logic [4:0] DaysFeb = 5'd28;
  localparam logic signed [6:0] HoursPerDay = 7'sd24;
  localparam logic [4:0] HourNoon = 5'd12;
  localparam logic [3:0] TwelveNoon = 4'd12;

  // Divisibility by 25 on a 10-bit value: x * inv(25) mod 1024 <= 1023 / 25
  localparam logic [9:0] Div25Inv = 10'd41;
  localparam logic [9:0] Div25Max = 10'd40;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } utc_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        fwd;
    logic        bwd;
    logic [3:0]  len_month;
    logic [9:0]  yprod;
  } prep_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        fwd;
    logic        bwd;
    logic        roll;
    logic [4:0]  len;
  } roll_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [3:0]  twelve;
    logic        pm;
  } lcl_t;

  // Gregorian month length; odd months up to July and even months from August are long
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MonthFeb) begin
      len = leap ? DaysFebLeap : DaysFeb;
    end else if ((m <= MonthJul && m[0]) || (m >= MonthAug && !m[0])) begin
      len = DaysLong;
    end else begin
      len = DaysShort;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tzda_if.sv @@
`default_nettype none

interface tzda_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] utc_year;
  logic [3:0]  utc_month;
  logic [4:0]  utc_day;
  logic [4:0]  utc_hour;
  logic [5:0]  utc_minute;

  modport source (output valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                  input ready);
  modport sink (input valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                output ready);
endinterface

interface tzda_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] local_year;
  logic [3:0]  local_month;
  logic [4:0]  local_day;
  logic [4:0]  local_hour;
  logic [5:0]  local_minute;
  logic [3:0]  hour_twelve;
  logic        is_pm;

  modport source (output valid, local_year, local_month, local_day, local_hour,
                  local_minute, hour_twelve, is_pm, input ready);
  modport sink (input valid, local_year, local_month, local_day, local_hour,
                local_minute, hour_twelve, is_pm, output ready);
endinterface

interface tzda_cfg_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] zone_offset_hours;

  modport source (output valid, zone_offset_hours, input ready);
  modport sink (input valid, zone_offset_hours, output ready);
endinterface

`default_nettype wire

@@ rtl/tzda_prep.sv @@
`default_nettype none

module tzda_prep
  import tzda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  utc_t              in_data,
  input  logic signed [4:0] offset,
  output logic              out_valid,
  input  logic              out_ready,
  output prep_t             out_data
);

  logic signed [6:0] hsum;
  logic signed [6:0] hadj;
  prep_t             stage_next;

  // Add the zone offset and classify the day step
  always_comb begin
    hsum = $signed({2'b00, in_data.hour}) + $signed({{2{offset[4]}}, offset});
    stage_next.fwd = (hsum >= HoursPerDay);
    stage_next.bwd = hsum[6];
    if (stage_next.fwd) begin
      hadj = hsum - HoursPerDay;
    end else if (stage_next.bwd) begin
      hadj = hsum + HoursPerDay;
    end else begin
      hadj = hsum;
    end
    stage_next.hour   = hadj[4:0];
    stage_next.year   = in_data.year;
    stage_next.month  = in_data.month;
    stage_next.day    = in_data.day;
    stage_next.minute = in_data.minute;
    // Month whose length matters: this one going forward, the previous one going back
    if (stage_next.bwd) begin
      stage_next.len_month = (in_data.month <= MonthJan) ? MonthDec
                                                         : 4'(in_data.month - 4'd1);
    end else begin
      stage_next.len_month = in_data.month;
    end
    // Residue product for the divide-by-25 test of year / 4
    stage_next.yprod = 10'(in_data.year[11:2] * Div25Inv);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tzda_roll.sv @@
`default_nettype none

module tzda_roll
  import tzda_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prep_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output roll_t out_data
);

  logic  div25;
  logic  leap;
  roll_t stage_next;

  // Leap year test and month length, then decide whether the month rolls
  always_comb begin
    div25 = (in_data.yprod <= Div25Max);
    leap  = ((in_data.year[3:0] == 4'd0) && div25) ||
            ((in_data.year[1:0] == 2'd0) && !div25);
    stage_next.len    = month_len(in_data.len_month, leap);
    stage_next.year   = in_data.year;
    stage_next.month  = in_data.month;
    stage_next.day    = in_data.day;
    stage_next.hour   = in_data.hour;
    stage_next.minute = in_data.minute;
    stage_next.fwd    = in_data.fwd;
    stage_next.bwd    = in_data.bwd;
    if (in_data.fwd) begin
      stage_next.roll = (({1'b0, in_data.day} + 6'd1) > {1'b0, stage_next.len});
    end else if (in_data.bwd) begin
      stage_next.roll = (in_data.day <= 5'd1);
    end else begin
      stage_next.roll = 1'b0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tzda_fmt.sv @@
`default_nettype none

module tzda_fmt
  import tzda_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  roll_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output lcl_t  out_data
);

  lcl_t stage_next;

  // Apply the day step with month and year carry, and build the 12-hour view
  always_comb begin
    stage_next.year   = in_data.year;
    stage_next.month  = in_data.month;
    stage_next.day    = in_data.day;
    stage_next.hour   = in_data.hour;
    stage_next.minute = in_data.minute;
    if (in_data.fwd) begin
      if (in_data.roll) begin
        stage_next.day = 5'd1;
        if (in_data.month >= MonthDec) begin
          stage_next.month = MonthJan;
          stage_next.year  = 12'(in_data.year + 12'd1);
        end else begin
          stage_next.month = 4'(in_data.month + 4'd1);
        end
      end else begin
        stage_next.day = 5'(in_data.day + 5'd1);
      end
    end else if (in_data.bwd) begin
      if (in_data.roll) begin
        stage_next.day = in_data.len;
        if (in_data.month <= MonthJan) begin
          stage_next.month = MonthDec;
          stage_next.year  = 12'(in_data.year - 12'd1);
        end else begin
          stage_next.month = 4'(in_data.month - 4'd1);
        end
      end else begin
        stage_next.day = 5'(in_data.day - 5'd1);
      end
    end
    stage_next.pm = (in_data.hour >= HourNoon);
    if (in_data.hour == 5'd0) begin
      stage_next.twelve = TwelveNoon;
    end else if (in_data.hour > HourNoon) begin
      stage_next.twelve = 4'(in_data.hour - HourNoon);
    end else begin
      stage_next.twelve = in_data.hour[3:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/timezone_date_adjust.sv @@
// Time zone date adjust.
// Adds a signed whole-hour zone offset to a UTC timestamp and returns the
// local date and time, with a 12-hour view (hour_twelve, is_pm).
// Channels: utc_chan takes one timestamp per transfer (valid/ready),
// local_chan gives one result per timestamp in the same order, zone_cfg
// writes the offset register; zone_cfg is always ready and the offset is
// meant to change only while no item is in flight.
// Throughput: one item per cycle while local_chan is ready, set by three
// register stages (offset add, leap test and month length, day/month/year
// carry) each with its own valid bit; each result passes through all
// three before it shows on local_chan.
// A stall on local_chan holds each full stage; empty stages keep taking
// items, so up to three results wait inside before utc_chan drops ready.
// Reset: synchronous rst empties all stages and sets the offset to 0.
`default_nettype none

module timezone_date_adjust
  import tzda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tzda_cfg_if.sink   zone_cfg,
  tzda_in_if.sink    utc_chan,
  tzda_out_if.source local_chan
);

  logic signed [4:0] offset;
  utc_t              utc_data;
  prep_t             prep_data;
  roll_t             roll_data;
  lcl_t              lcl_data;
  logic              prep_valid;
  logic              prep_ready;
  logic              roll_valid;
  logic              roll_ready;

  // Hold the zone offset
  assign zone_cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 5'sd0;
    end else if (zone_cfg.valid) begin
      offset <= zone_cfg.zone_offset_hours;
    end
  end

  assign utc_data.year   = utc_chan.utc_year;
  assign utc_data.month  = utc_chan.utc_month;
  assign utc_data.day    = utc_chan.utc_day;
  assign utc_data.hour   = utc_chan.utc_hour;
  assign utc_data.minute = utc_chan.utc_minute;

  tzda_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (utc_chan.valid),
    .in_ready  (utc_chan.ready),
    .in_data   (utc_data),
    .offset    (offset),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  tzda_roll u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (roll_valid),
    .out_ready (roll_ready),
    .out_data  (roll_data)
  );

  tzda_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (roll_valid),
    .in_ready  (roll_ready),
    .in_data   (roll_data),
    .out_valid (local_chan.valid),
    .out_ready (local_chan.ready),
    .out_data  (lcl_data)
  );

  assign local_chan.local_year   = lcl_data.year;
  assign local_chan.local_month  = lcl_data.month;
  assign local_chan.local_day    = lcl_data.day;
  assign local_chan.local_hour   = lcl_data.hour;
  assign local_chan.local_minute = lcl_data.minute;
  assign local_chan.hour_twelve  = lcl_data.twelve;
  assign local_chan.is_pm        = lcl_data.pm;

`ifndef NO_ASSERTIONS
  // Local hour always lands inside one day
  assert property (@(posedge clk) disable iff (rst)
    local_chan.valid |-> local_chan.local_hour < 5'd24)
    else $error("local hour out of range");

  // 12-hour view agrees with the 24-hour value
  assert property (@(posedge clk) disable iff (rst)
    local_chan.valid |-> (local_chan.hour_twelve >= 4'd1 && local_chan.hour_twelve <= 4'd12 &&
                          local_chan.is_pm == (local_chan.local_hour >= 5'd12)))
    else $error("12-hour view mismatch");

  // Pipeline is empty right after reset
  assert property (@(posedge clk)
    $past(rst) |-> (!local_chan.valid && !prep_valid && !roll_valid))
    else $error("stage valid after reset");
`endif

endmodule

`default_nettype wire

@@ dv/timezone_date_adjust_tb.sv @@
`timescale 1ns / 100ps

module timezone_date_adjust_tb
  import tzda_pkg::*;
();

  localparam int DayHours = 24;
  localparam int YearSpan = 4096;
  localparam int LongHoldCycles = 90;
  localparam int DrainCycles = 12;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 325;

  logic clk = 1'b0;
  logic rst;

  tzda_cfg_if zone_if ();
  tzda_in_if  utc_if ();
  tzda_out_if local_if ();

  timezone_date_adjust dut (
    .clk        (clk),
    .rst        (rst),
    .zone_cfg   (zone_if),
    .utc_chan   (utc_if),
    .local_chan (local_if)
  );

  // Offset currently programmed, mirrored on each register transfer
  logic signed [4:0] zone_offset = 5'sd0;

  utc_t utc_pending[$];
  lcl_t local_expected[$];

  int send_gap;
  int send_gap_max = 4;
  int recv_gap;
  int recv_gap_max = 4;
  int long_hold;
  int hold_req = 0;
  int hold_ack;
  int error_count = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  // Gregorian month length; odd months through July and even months from August are long
  function automatic int days_in_month(int mon, int yr);
    bit leap;
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    if (mon == 2) begin
      return leap ? 29 : 28;
    end
    if ((mon <= 7 && (mon % 2) != 0) || (mon >= 8 && (mon % 2) == 0)) begin
      return 31;
    end
    return 30;
  endfunction

  // Apply the zone offset and carry through day, month and year
  function automatic lcl_t shift_to_local(utc_t t, logic signed [4:0] off);
    lcl_t r;
    int yr;
    int mon;
    int dy;
    int hr;
    int len;
    yr = t.year;
    mon = t.month;
    dy = t.day;
    hr = int'(t.hour) + int'(off);
    if (hr >= DayHours) begin
      len = days_in_month(mon, yr);
      hr -= DayHours;
      dy++;
      if (dy > len) begin
        dy = 1;
        mon++;
        if (mon > 12) begin
          mon = 1;
          yr = (yr + 1) % YearSpan;
        end
      end
    end else if (hr < 0) begin
      hr += DayHours;
      dy--;
      if (dy < 1) begin
        mon--;
        if (mon < 1) begin
          mon = 12;
          yr = (yr + YearSpan - 1) % YearSpan;
        end
        dy = days_in_month(mon, yr);
      end
    end
    r.year = yr[11:0];
    r.month = mon[3:0];
    r.day = dy[4:0];
    r.hour = hr[4:0];
    r.minute = t.minute;
    r.twelve = (hr == 0) ? 4'd12 : (hr > 12) ? 4'(hr - 12) : 4'(hr);
    r.pm = (hr >= 12);
    return r;
  endfunction

  // Mostly well-formed timestamps near day and month edges, some raw noise
  function automatic utc_t random_utc();
    utc_t t;
    int yr;
    int mon;
    int len;
    if ($urandom_range(0, 15) == 0) begin
      t = utc_t'($urandom);
      return t;
    end
    case ($urandom_range(0, 7))
      0: yr = 2000;
      1: yr = 2100;
      2: yr = 2024;
      3: yr = ($urandom_range(0, 1) == 0) ? 1 : 4000;
      default: yr = $urandom_range(1, 4000);
    endcase
    mon = $urandom_range(1, 12);
    len = days_in_month(mon, yr);
    t.year = yr[11:0];
    t.month = mon[3:0];
    case ($urandom_range(0, 3))
      0: t.day = 5'd1;
      1: t.day = len[4:0];
      2: t.day = 5'(len - 1);
      default: t.day = 5'($urandom_range(1, len));
    endcase
    t.hour = 5'($urandom_range(0, 23));
    t.minute = 6'($urandom_range(0, 59));
    return t;
  endfunction

  task automatic add_utc(int yr, int mon, int dy, int hr, int mi);
    utc_t t;
    t.year = yr[11:0];
    t.month = mon[3:0];
    t.day = dy[4:0];
    t.hour = hr[4:0];
    t.minute = mi[5:0];
    utc_pending.push_back(t);
  endtask

  // Hold until every queued timestamp has gone in and every result has come out
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (utc_pending.size() != 0 || utc_if.valid || local_expected.size() != 0);
  endtask

  task automatic write_zone(logic signed [4:0] off);
    wait_drained();
    @(posedge clk);
    zone_if.valid <= 1'b1;
    zone_if.zone_offset_hours <= off;
    do begin
      @(posedge clk);
    end while (!zone_if.ready);
    zone_if.valid <= 1'b0;
    zone_offset = off;
  endtask

  task automatic run_random_phase(logic signed [4:0] off, int sgap, int rgap, bit hold);
    write_zone(off);
    send_gap_max = sgap;
    recv_gap_max = rgap;
    if (hold) begin
      hold_req++;
    end
    for (int i = 0; i < PhaseItems; i++) begin
      utc_pending.push_back(random_utc());
    end
    wait_drained();
  endtask

  // Offer queued timestamps; predict each one on its transfer
  always @(posedge clk) begin : utc_driver
    utc_t item;
    utc_t seen;
    if (rst) begin
      utc_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (utc_if.valid && utc_if.ready) begin
        seen.year = utc_if.utc_year;
        seen.month = utc_if.utc_month;
        seen.day = utc_if.utc_day;
        seen.hour = utc_if.utc_hour;
        seen.minute = utc_if.utc_minute;
        local_expected.push_back(shift_to_local(seen, zone_offset));
      end
      if (!utc_if.valid || utc_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          utc_if.valid <= 1'b0;
        end else if (utc_pending.size() != 0) begin
          item = utc_pending.pop_front();
          utc_if.valid <= 1'b1;
          utc_if.utc_year <= item.year;
          utc_if.utc_month <= item.month;
          utc_if.utc_day <= item.day;
          utc_if.utc_hour <= item.hour;
          utc_if.utc_minute <= item.minute;
          send_gap <= $urandom_range(0, send_gap_max);
        end else begin
          utc_if.valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer and pace ready
  always @(posedge clk) begin : local_monitor
    lcl_t want;
    int unsigned g;
    if (rst) begin
      local_if.ready <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
      hold_ack <= hold_req;
    end else begin
      if (local_if.valid && local_if.ready) begin
        if (local_expected.size() == 0) begin
          $error("local result with no expected entry");
          error_count++;
        end else begin
          want = local_expected.pop_front();
          if (local_if.local_year !== want.year) begin
            $error("local_year: expected %0d, got %0d", want.year, local_if.local_year);
            error_count++;
          end
          if (local_if.local_month !== want.month) begin
            $error("local_month: expected %0d, got %0d", want.month, local_if.local_month);
            error_count++;
          end
          if (local_if.local_day !== want.day) begin
            $error("local_day: expected %0d, got %0d", want.day, local_if.local_day);
            error_count++;
          end
          if (local_if.local_hour !== want.hour) begin
            $error("local_hour: expected %0d, got %0d", want.hour, local_if.local_hour);
            error_count++;
          end
          if (local_if.local_minute !== want.minute) begin
            $error("local_minute: expected %0d, got %0d", want.minute, local_if.local_minute);
            error_count++;
          end
          if (local_if.hour_twelve !== want.twelve) begin
            $error("hour_twelve: expected %0d, got %0d", want.twelve, local_if.hour_twelve);
            error_count++;
          end
          if (local_if.is_pm !== want.pm) begin
            $error("is_pm: expected %0d, got %0d", want.pm, local_if.is_pm);
            error_count++;
          end
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack <= hold_req;
        long_hold <= LongHoldCycles;
        local_if.ready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        local_if.ready <= (long_hold == 1);
      end else if (local_if.valid && local_if.ready) begin
        g = $urandom_range(0, recv_gap_max);
        recv_gap <= g;
        local_if.ready <= (g == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        local_if.ready <= (recv_gap == 1);
      end else begin
        local_if.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    zone_if.valid = 1'b0;
    zone_if.zone_offset_hours = 5'sd0;
    utc_if.valid = 1'b0;
    utc_if.utc_year = '0;
    utc_if.utc_month = '0;
    utc_if.utc_day = '0;
    utc_if.utc_hour = '0;
    utc_if.utc_minute = '0;
    local_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset offset of zero: midnight and noon in the 12-hour view
    add_utc(2024, 2, 29, 0, 0);
    add_utc(2023, 6, 15, 12, 59);

    // Mostly forward rolls at the largest legal offset, plus malformed fields
    write_zone(5'sd12);
    add_utc(2023, 12, 31, 12, 30);
    add_utc(2024, 2, 28, 12, 0);
    add_utc(2023, 2, 28, 12, 0);
    add_utc(2100, 2, 28, 23, 0);
    add_utc(2000, 2, 28, 15, 0);
    add_utc(4000, 12, 31, 23, 59);
    add_utc(4095, 12, 31, 20, 0);
    add_utc(1, 4, 30, 11, 0);
    add_utc(2023, 0, 31, 12, 0);
    add_utc(2023, 15, 30, 12, 63);
    add_utc(2023, 6, 0, 12, 0);
    add_utc(2023, 5, 31, 31, 0);

    // Mostly backward rolls at the smallest legal offset, plus malformed fields
    write_zone(-5'sd12);
    add_utc(1, 1, 1, 0, 0);
    add_utc(2024, 3, 1, 5, 0);
    add_utc(2100, 3, 1, 11, 0);
    add_utc(0, 1, 1, 3, 0);
    add_utc(2023, 8, 1, 6, 0);
    add_utc(2023, 5, 1, 0, 0);
    add_utc(2023, 7, 0, 4, 0);
    add_utc(2023, 0, 5, 2, 0);
    add_utc(2023, 0, 1, 2, 0);
    add_utc(2023, 13, 1, 12, 0);

    // Offsets beyond the meant range, both register extremes
    write_zone(5'sd15);
    add_utc(2023, 9, 30, 9, 0);
    write_zone(-5'sd16);
    add_utc(2023, 10, 1, 15, 0);

    // Random phases over several offsets and idle patterns
    run_random_phase(5'sd3, 0, 0, 1'b0);
    run_random_phase(-5'sd12, 12, 12, 1'b0);
    run_random_phase(5'sd12, 0, 3, 1'b1);
    run_random_phase(-5'sd7, 12, 0, 1'b0);
    run_random_phase(5'($urandom_range(0, 31)), 0, 12, 1'b0);
    run_random_phase(5'sd1, 5, 5, 1'b0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tzda_pkg.sv
rtl/tzda_if.sv
rtl/tzda_prep.sv
rtl/tzda_roll.sv
rtl/tzda_fmt.sv
rtl/timezone_date_adjust.sv
dv/timezone_date_adjust_tb.sv
